// File: rtl/core/rtph264_pkg.sv
// ----------------------------------------------------------------------------
// rtph264_pkg
// Shared types and constants for the RTP H.264 packetiser.
// ----------------------------------------------------------------------------
package rtph264_pkg;

    localparam int NAL_LENGTH_BITS = 22;

    localparam logic [1:0] CFG_PAYLOAD_TYPE = 2'd0;
    localparam logic [1:0] CFG_SOURCE_ID    = 2'd1;
    localparam logic [1:0] CFG_TS_INCREMENT = 2'd2;
    localparam logic [1:0] CFG_MAX_PACKET   = 2'd3;

    localparam logic [6:0]  PT_RESET      = 7'd96;
    localparam logic [31:0] SSRC_RESET    = 32'hd160b58f;
    localparam logic [31:0] TS_INC_RESET  = 32'd3600;
    localparam logic [15:0] MAX_PKT_RESET = 16'd1400;

    localparam logic [15:0] MIN_PACKET    = 16'd16;
    localparam logic [15:0] RTP_HDR_BYTES = 16'd12;
    localparam logic [15:0] FU_OVERHEAD   = 16'd14;

    localparam logic [7:0] RTP_VERSION_BYTE = 8'h80;
    localparam logic [7:0] NRI_MASK         = 8'he0;
    localparam logic [7:0] FU_A_TYPE        = 8'd28;
    localparam logic [7:0] TYPE_MASK        = 8'h1f;
    localparam logic [7:0] FU_START_BIT     = 8'h80;
    localparam logic [7:0] FU_END_BIT       = 8'h40;

    typedef struct packed {
        logic [7:0]                 nal_byte;
        logic [NAL_LENGTH_BITS-1:0] nal_length;
        logic                       first_byte;
    } nal_item_t;

    typedef struct packed {
        logic [7:0] packet_byte;
        logic       packet_end;
        logic       run_last;
    } pkt_item_t;

    typedef struct packed {
        logic [6:0]  payload_type;
        logic [31:0] source_id;
        logic [31:0] ts_increment;
        logic [15:0] max_packet_bytes;
    } cfg_t;

    // One request for the back end: optional RTP header, optional FU-A
    // bytes, then exactly one payload byte.
    typedef struct packed {
        logic        hdr;
        logic        marker;
        logic        fu;
        logic        pkt_end;
        logic [15:0] seq;
        logic [31:0] ts;
        logic [7:0]  fu_ind;
        logic [7:0]  fu_hdr;
        logic [7:0]  data;
    } job_t;

endpackage

// File: rtl/core/rtph264_front.sv
// ----------------------------------------------------------------------------
// rtph264_front
// Takes NAL bytes, tracks NAL/fragment state and issues byte-run requests.
// ----------------------------------------------------------------------------
module rtph264_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  rtph264_pkg::cfg_t       cfg,
    input  logic                    accept,
    input  rtph264_pkg::nal_item_t  item,
    output logic                    job_push,
    output rtph264_pkg::job_t       job
);
    import rtph264_pkg::*;

    localparam logic [NAL_LENGTH_BITS-1:0] LEN_ONE = NAL_LENGTH_BITS'(1);

    logic [15:0]                seq_reg, seq_next;
    logic [31:0]                ts_reg, ts_next;
    logic                       second_reg, second_next;
    logic [15:0]                fill_reg, fill_next;
    logic [7:0]                 nal_hdr_reg, nal_hdr_next;
    logic                       frag_reg, frag_next;
    logic [NAL_LENGTH_BITS-1:0] remain_reg, remain_next;

    logic [15:0]                psize;
    logic [15:0]                frag_cap;
    logic [15:0]                single_cap;
    logic [15:0]                fill_inc;
    logic [NAL_LENGTH_BITS-1:0] len_eff;
    logic                       last_frag;
    logic                       frag_end;
    logic                       nal_done;

    always_comb
    begin
        psize      = (cfg.max_packet_bytes < MIN_PACKET) ? MIN_PACKET : cfg.max_packet_bytes;
        frag_cap   = psize - FU_OVERHEAD;
        single_cap = psize - RTP_HDR_BYTES;
        len_eff    = (item.nal_length == '0) ? LEN_ONE : item.nal_length;
        fill_inc   = fill_reg + 16'd1;
        nal_done   = (remain_reg == LEN_ONE);
        last_frag  = (remain_reg <= NAL_LENGTH_BITS'(frag_cap));
        frag_end   = (fill_inc >= frag_cap) || nal_done;

        seq_next     = seq_reg;
        ts_next      = ts_reg;
        second_next  = second_reg;
        fill_next    = fill_reg;
        nal_hdr_next = nal_hdr_reg;
        frag_next    = frag_reg;
        remain_next  = remain_reg;

        job_push = 1'b0;
        job      = '0;
        job.seq  = seq_reg;
        job.ts   = ts_reg;
        job.data = item.nal_byte;
        job.fu_ind = (nal_hdr_reg & NRI_MASK) | FU_A_TYPE;
        job.fu_hdr = (nal_hdr_reg & TYPE_MASK)
                   | (second_reg ? FU_START_BIT : 8'h00)
                   | (last_frag ? FU_END_BIT : 8'h00);

        if (accept)
        begin
            if (item.first_byte)
            begin
                second_next  = 1'b1;
                remain_next  = len_eff - LEN_ONE;
                nal_hdr_next = item.nal_byte;
                fill_next    = '0;
                if (len_eff <= NAL_LENGTH_BITS'(single_cap))
                begin
                    frag_next   = 1'b0;
                    job_push    = 1'b1;
                    job.hdr     = 1'b1;
                    job.marker  = 1'b1;
                    job.pkt_end = (len_eff == LEN_ONE);
                    if (len_eff == LEN_ONE)
                    begin
                        seq_next = seq_reg + 16'd1;
                        ts_next  = ts_reg + cfg.ts_increment;
                    end
                end
                else
                begin
                    frag_next = 1'b1;
                end
            end
            else if (remain_reg != '0)
            begin
                second_next = 1'b0;
                remain_next = remain_reg - LEN_ONE;
                job_push    = 1'b1;
                if (!frag_reg)
                begin
                    job.pkt_end = nal_done;
                    if (nal_done)
                    begin
                        seq_next = seq_reg + 16'd1;
                        ts_next  = ts_reg + cfg.ts_increment;
                    end
                end
                else
                begin
                    if (fill_reg == '0)
                    begin
                        job.hdr    = 1'b1;
                        job.fu     = 1'b1;
                        job.marker = last_frag;
                    end
                    job.pkt_end = frag_end;
                    fill_next   = frag_end ? 16'd0 : fill_inc;
                    if (frag_end)
                        seq_next = seq_reg + 16'd1;
                    if (nal_done)
                        ts_next = ts_reg + cfg.ts_increment;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg     <= '0;
            ts_reg      <= '0;
            second_reg  <= 1'b0;
            fill_reg    <= '0;
            nal_hdr_reg <= '0;
            frag_reg    <= 1'b0;
            remain_reg  <= '0;
        end
        else
        begin
            seq_reg     <= seq_next;
            ts_reg      <= ts_next;
            second_reg  <= second_next;
            fill_reg    <= fill_next;
            nal_hdr_reg <= nal_hdr_next;
            frag_reg    <= frag_next;
            remain_reg  <= remain_next;
        end
    end

endmodule

// File: rtl/core/rtph264_jobq.sv
// ----------------------------------------------------------------------------
// rtph264_jobq
// Four-entry request queue between front and back end.
// ----------------------------------------------------------------------------
module rtph264_jobq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr,
    input  rtph264_pkg::job_t wr_job,
    output logic              full,
    input  logic              rd,
    output rtph264_pkg::job_t rd_job,
    output logic              empty
);
    import rtph264_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [PTR_W-1:0] rp_reg, rp_next;
    logic [PTR_W:0]   cnt_reg, cnt_next;

    assign full   = (cnt_reg == (PTR_W+1)'(DEPTH));
    assign empty  = (cnt_reg == '0);
    assign rd_job = mem_reg[rp_reg];

    always_comb
    begin
        wp_next  = wr ? wp_reg + 1'b1 : wp_reg;
        rp_next  = rd ? rp_reg + 1'b1 : rp_reg;
        cnt_next = cnt_reg + (PTR_W+1)'(wr) - (PTR_W+1)'(rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wp_reg] <= wr_job;
    end

endmodule

// File: rtl/core/rtph264_back.sv
// ----------------------------------------------------------------------------
// rtph264_back
// Expands requests into packet bytes, one per cycle while pop keeps up, into the output register.
// ----------------------------------------------------------------------------
module rtph264_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  rtph264_pkg::cfg_t      cfg,
    input  rtph264_pkg::job_t      q_job,
    input  logic                   q_empty,
    output logic                   q_pop,
    output rtph264_pkg::pkt_item_t packet,
    output logic                   empty,
    input  logic                   pop
);
    import rtph264_pkg::*;

    localparam logic [3:0] IX_VER      = 4'd0;
    localparam logic [3:0] IX_MPT      = 4'd1;
    localparam logic [3:0] IX_SEQ_HI   = 4'd2;
    localparam logic [3:0] IX_SEQ_LO   = 4'd3;
    localparam logic [3:0] IX_TS_3     = 4'd4;
    localparam logic [3:0] IX_TS_2     = 4'd5;
    localparam logic [3:0] IX_TS_1     = 4'd6;
    localparam logic [3:0] IX_TS_0     = 4'd7;
    localparam logic [3:0] IX_SSRC_3   = 4'd8;
    localparam logic [3:0] IX_SSRC_2   = 4'd9;
    localparam logic [3:0] IX_SSRC_1   = 4'd10;
    localparam logic [3:0] IX_SSRC_0   = 4'd11;
    localparam logic [3:0] IX_FU_IND   = 4'd12;
    localparam logic [3:0] IX_FU_HDR   = 4'd13;
    localparam logic [3:0] IX_PAYLOAD  = 4'd14;

    job_t      cur_reg, cur_next;
    logic      cur_valid_reg, cur_valid_next;
    logic [3:0] idx_reg, idx_next;
    pkt_item_t out_reg, out_next;
    logic      out_valid_reg, out_valid_next;

    logic      adv;
    logic      cur_done;
    logic [7:0] byte_sel;

    always_comb
    begin
        case (idx_reg)
            IX_VER:     byte_sel = RTP_VERSION_BYTE;
            IX_MPT:     byte_sel = {cur_reg.marker, cfg.payload_type};
            IX_SEQ_HI:  byte_sel = cur_reg.seq[15:8];
            IX_SEQ_LO:  byte_sel = cur_reg.seq[7:0];
            IX_TS_3:    byte_sel = cur_reg.ts[31:24];
            IX_TS_2:    byte_sel = cur_reg.ts[23:16];
            IX_TS_1:    byte_sel = cur_reg.ts[15:8];
            IX_TS_0:    byte_sel = cur_reg.ts[7:0];
            IX_SSRC_3:  byte_sel = cfg.source_id[31:24];
            IX_SSRC_2:  byte_sel = cfg.source_id[23:16];
            IX_SSRC_1:  byte_sel = cfg.source_id[15:8];
            IX_SSRC_0:  byte_sel = cfg.source_id[7:0];
            IX_FU_IND:  byte_sel = cur_reg.fu_ind;
            IX_FU_HDR:  byte_sel = cur_reg.fu_hdr;
            default:    byte_sel = cur_reg.data;
        endcase
    end

    always_comb
    begin
        adv      = cur_valid_reg && (!out_valid_reg || pop);
        cur_done = adv && (idx_reg == IX_PAYLOAD);
        q_pop    = (!cur_valid_reg || cur_done) && !q_empty;

        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (adv)
        begin
            out_next.packet_byte = byte_sel;
            out_next.packet_end  = cur_done && cur_reg.pkt_end;
            out_next.run_last    = cur_done;
            out_valid_next       = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end

        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        if (q_pop)
        begin
            cur_next       = q_job;
            cur_valid_next = 1'b1;
            idx_next       = q_job.hdr ? IX_VER : IX_PAYLOAD;
        end
        else if (cur_done)
        begin
            cur_valid_next = 1'b0;
        end
        else if (adv)
        begin
            idx_next = (idx_reg == IX_SSRC_0 && !cur_reg.fu) ? IX_PAYLOAD : idx_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        out_reg <= out_next;
    end

    assign packet = out_reg;
    assign empty  = !out_valid_reg;

endmodule

// File: rtl/core/rtp_h264_packetizer.sv
// ----------------------------------------------------------------------------
// rtp_h264_packetizer
// H.264 NAL to RTP packet byte stream (single NAL and FU-A modes).
// ----------------------------------------------------------------------------
// Input queue: drive nal and push; a byte is taken when push is high and
// full is low. NAL bytes arrive in order, first_byte marking the NAL header.
// Output queue: while empty is low, packet holds the oldest byte; pop takes it.
// Each input byte yields 0 to 15 output bytes (12-byte RTP header and, for
// FU-A, two FU bytes ahead of the payload byte); run_last flags the last one.
// Path: job queue, then request register, then output register.
// Throughput: one input byte per cycle, limited by the back end emitting one
// packet byte per cycle while pop keeps up; header bursts are absorbed by a
// four-entry queue and then push back through full.
// Configuration: cfg_we writes cfg_data into register cfg_index at the clock
// edge; write only while no bytes are in flight.
// Reset: registers return to their defaults, counters clear, queues empty.
// A stalled receiver holds the output byte; the queue then fills and full
// rises until pop resumes.
// ----------------------------------------------------------------------------
module rtp_h264_packetizer (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  rtph264_pkg::nal_item_t nal,
    output logic                   full,
    input  logic                   pop,
    output rtph264_pkg::pkt_item_t packet,
    output logic                   empty,
    input  logic                   cfg_we,
    input  logic [1:0]             cfg_index,
    input  logic [31:0]            cfg_data
);
    import rtph264_pkg::*;

    cfg_t cfg_reg, cfg_next;
    logic accept;
    logic job_push;
    job_t job_in;
    job_t job_out;
    logic q_empty;
    logic q_pop;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_PAYLOAD_TYPE: cfg_next.payload_type     = cfg_data[6:0];
                CFG_SOURCE_ID:    cfg_next.source_id        = cfg_data;
                CFG_TS_INCREMENT: cfg_next.ts_increment     = cfg_data;
                CFG_MAX_PACKET:   cfg_next.max_packet_bytes = cfg_data[15:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.payload_type     <= PT_RESET;
            cfg_reg.source_id        <= SSRC_RESET;
            cfg_reg.ts_increment     <= TS_INC_RESET;
            cfg_reg.max_packet_bytes <= MAX_PKT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign accept = push && !full;

    rtph264_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .accept   (accept),
        .item     (nal),
        .job_push (job_push),
        .job      (job_in)
    );

    rtph264_jobq u_jobq (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (job_push),
        .wr_job (job_in),
        .full   (full),
        .rd     (q_pop),
        .rd_job (job_out),
        .empty  (q_empty)
    );

    rtph264_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_job   (job_out),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .packet  (packet),
        .empty   (empty),
        .pop     (pop)
    );

endmodule

// File: rtl/core/rtph264_checker.sv
// ----------------------------------------------------------------------------
// rtph264_checker
// Port-level checks on the packetiser's output queue.
// ----------------------------------------------------------------------------
module rtph264_checker (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   pop,
    input logic                   empty,
    input rtph264_pkg::pkt_item_t packet
);

    // reset may first be seen at a clock edge, so empty is checked at the next edge
    a_empty_in_reset: assert property (@(posedge clk) !rst_n |=> empty)
        else $error("output not empty during reset");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(packet)))
        else $error("stalled output byte changed");

    a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && packet.packet_end) |-> packet.run_last)
        else $error("packet end not on last byte of a run");

endmodule

bind rtp_h264_packetizer rtph264_checker u_checker (.*);

// File: tb/sv/rtp_stream_checker.sv
// ----------------------------------------------------------------------------
// rtp_stream_checker
// Watches the NAL input and RTP output queues of the packetiser. Each accepted
// NAL byte is run through a local model of the RTP/FU-A framing, and the
// packet bytes it should produce are queued. Every popped packet byte is
// compared field by field against the oldest queued byte.
// ----------------------------------------------------------------------------
module rtp_stream_checker (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  rtph264_pkg::nal_item_t nal,
    input  logic                   full,
    input  logic                   pop,
    input  rtph264_pkg::pkt_item_t packet,
    input  logic                   empty,
    input  logic                   cfg_we,
    input  logic [1:0]             cfg_index,
    input  logic [31:0]            cfg_data,
    output int                     fail_count,
    output int                     pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import rtph264_pkg::*;

    logic [6:0]  pt;
    logic [31:0] ssrc;
    logic [31:0] ts_step;
    logic [15:0] max_pkt;

    logic [15:0] seq_num;
    logic [31:0] rtp_ts;
    logic [21:0] nal_pos;
    logic [15:0] frag_fill;
    logic [7:0]  nal_hdr;
    logic        fragmenting;
    logic [21:0] remaining;

    pkt_item_t   expected_bytes[$];
    int          popped;

    task automatic report(input string what);
        fail_count++;
        if (fail_count <= 200)
            $display("%0t: packet byte %0d: %s", $time, popped, what);
    endtask

    task automatic put_byte(input logic [7:0] b, input logic ends);
        expected_bytes.push_back(pkt_item_t'{packet_byte: b, packet_end: ends, run_last: 1'b0});
    endtask

    task automatic put_rtp_header(input logic marker);
        put_byte(RTP_VERSION_BYTE, 1'b0);
        put_byte({marker, pt}, 1'b0);
        put_byte(seq_num[15:8], 1'b0);
        put_byte(seq_num[7:0], 1'b0);
        put_byte(rtp_ts[31:24], 1'b0);
        put_byte(rtp_ts[23:16], 1'b0);
        put_byte(rtp_ts[15:8], 1'b0);
        put_byte(rtp_ts[7:0], 1'b0);
        put_byte(ssrc[31:24], 1'b0);
        put_byte(ssrc[23:16], 1'b0);
        put_byte(ssrc[15:8], 1'b0);
        put_byte(ssrc[7:0], 1'b0);
    endtask

    // one request in, zero to fifteen packet bytes out
    task automatic packetise(input nal_item_t it);
        int unsigned psize;
        int unsigned cap;
        int unsigned len;
        int          base;
        logic        last_frag;
        logic        closes;
        logic [7:0]  fu_hdr;
        pkt_item_t   tail;
        psize = 32'((max_pkt < MIN_PACKET) ? MIN_PACKET : max_pkt);
        cap   = psize - 32'(FU_OVERHEAD);
        base  = expected_bytes.size();
        if (it.first_byte)
        begin
            len         = (it.nal_length == '0) ? 32'd1 : 32'(it.nal_length);
            nal_pos     = 22'd1;
            remaining   = 22'(len - 32'd1);
            nal_hdr     = it.nal_byte;
            frag_fill   = '0;
            if (len <= psize - 32'(RTP_HDR_BYTES))
            begin
                fragmenting = 1'b0;
                put_rtp_header(1'b1);
                put_byte(it.nal_byte, remaining == '0);
                if (remaining == '0)
                begin
                    seq_num = seq_num + 16'd1;
                    rtp_ts  = rtp_ts + ts_step;
                end
            end
            else
                fragmenting = 1'b1;
        end
        else if (remaining != '0)
        begin
            nal_pos = nal_pos + 22'd1;
            if (!fragmenting)
            begin
                remaining = remaining - 22'd1;
                put_byte(it.nal_byte, remaining == '0);
                if (remaining == '0)
                begin
                    seq_num = seq_num + 16'd1;
                    rtp_ts  = rtp_ts + ts_step;
                end
            end
            else
            begin
                if (frag_fill == '0)
                begin
                    last_frag = (32'(remaining) <= cap);
                    fu_hdr    = nal_hdr & TYPE_MASK;
                    if (nal_pos == 22'd2)
                        fu_hdr = fu_hdr | FU_START_BIT;
                    if (last_frag)
                        fu_hdr = fu_hdr | FU_END_BIT;
                    put_rtp_header(last_frag);
                    put_byte((nal_hdr & NRI_MASK) | FU_A_TYPE, 1'b0);
                    put_byte(fu_hdr, 1'b0);
                end
                frag_fill = frag_fill + 16'd1;
                remaining = remaining - 22'd1;
                closes    = (32'(frag_fill) >= cap) || (remaining == '0);
                put_byte(it.nal_byte, closes);
                if (closes)
                begin
                    frag_fill = '0;
                    seq_num   = seq_num + 16'd1;
                    if (remaining == '0)
                        rtp_ts = rtp_ts + ts_step;
                end
            end
        end
        if (expected_bytes.size() > base)
        begin
            tail          = expected_bytes.pop_back();
            tail.run_last = 1'b1;
            expected_bytes.push_back(tail);
        end
    endtask

    task automatic compare_byte(input pkt_item_t got);
        pkt_item_t want;
        if (expected_bytes.size() == 0)
            report($sformatf("unexpected byte %02h", got.packet_byte));
        else
        begin
            want = expected_bytes.pop_front();
            if (got.packet_byte !== want.packet_byte)
                report($sformatf("packet_byte %02h, want %02h",
                                 got.packet_byte, want.packet_byte));
            if (got.packet_end !== want.packet_end)
                report($sformatf("packet_end %b, want %b", got.packet_end, want.packet_end));
            if (got.run_last !== want.run_last)
                report($sformatf("run_last %b, want %b", got.run_last, want.run_last));
        end
        popped++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pt          = PT_RESET;
            ssrc        = SSRC_RESET;
            ts_step     = TS_INC_RESET;
            max_pkt     = MAX_PKT_RESET;
            seq_num     = '0;
            rtp_ts      = '0;
            nal_pos     = '0;
            frag_fill   = '0;
            nal_hdr     = '0;
            fragmenting = 1'b0;
            remaining   = '0;
            popped      = 0;
            fail_count  = 0;
            expected_bytes.delete();
            pending    <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_PAYLOAD_TYPE: pt      = cfg_data[6:0];
                    CFG_SOURCE_ID:    ssrc    = cfg_data;
                    CFG_TS_INCREMENT: ts_step = cfg_data;
                    CFG_MAX_PACKET:   max_pkt = cfg_data[15:0];
                    default:          ;
                endcase
            end
            if (push && !full)
                packetise(nal);
            if (pop && !empty)
                compare_byte(packet);
            pending <= expected_bytes.size();
        end
    end

endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives NAL bytes into the RTP H.264 packetiser through random idling on
// both queues. A directed run covers zero length, stray bytes, abandoned NALs,
// the minimum packet size and a size change mid-NAL; random NAL streams under
// several register settings follow. The checker judges every packet byte.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rtph264_pkg::*;

    localparam int QUIET_LIMIT = 2000;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        push      = 1'b0;
    nal_item_t   nal       = '0;
    logic        pop       = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = CFG_PAYLOAD_TYPE;
    logic [31:0] cfg_data  = '0;
    logic        full;
    logic        empty;
    pkt_item_t   packet;
    int          fail_count;
    int          pending;
    int          send_idle = 0;
    int          recv_idle = 0;
    int          quiet     = 0;

    rtp_h264_packetizer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .nal       (nal),
        .full      (full),
        .pop       (pop),
        .packet    (packet),
        .empty     (empty),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    rtp_stream_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .nal        (nal),
        .full       (full),
        .pop        (pop),
        .packet     (packet),
        .empty      (empty),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        pop <= ($urandom_range(99) >= recv_idle);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                quiet <= 0;
            else if (quiet >= QUIET_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
            else
                quiet <= quiet + 1;
        end
    end

    task automatic offer_byte(input logic [7:0] b, input logic [21:0] len, input logic first);
        while ($urandom_range(99) < send_idle)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        nal  <= nal_item_t'{nal_byte: b, nal_length: len, first_byte: first};
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    // length field only matters on the first byte; later bytes carry noise
    task automatic offer_nal(input logic [21:0] len_field, input int unsigned count);
        offer_byte(8'($urandom), len_field, 1'b1);
        for (int i = 1; i < count; i++)
            offer_byte(8'($urandom), 22'($urandom), 1'b0);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_config(input logic [6:0] pt, input logic [31:0] ssrc,
                              input logic [31:0] ts_step, input logic [15:0] max_pkt);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_PAYLOAD_TYPE;
        cfg_data  <= {25'd0, pt};
        @(posedge clk);
        cfg_index <= CFG_SOURCE_ID;
        cfg_data  <= ssrc;
        @(posedge clk);
        cfg_index <= CFG_TS_INCREMENT;
        cfg_data  <= ts_step;
        @(posedge clk);
        cfg_index <= CFG_MAX_PACKET;
        cfg_data  <= {16'd0, max_pkt};
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic run_phase(input int s_idle, input int r_idle, input int unsigned items,
                             input int unsigned len_max, input bit pause_midway);
        int unsigned done;
        int unsigned len;
        int unsigned cut;
        logic [21:0] field;
        bit          paused;
        send_idle = s_idle;
        recv_idle = r_idle;
        done      = 0;
        paused    = 1'b0;
        while (done < items)
        begin
            if ($urandom_range(99) < 5)
                offer_byte(8'($urandom), 22'($urandom), 1'b0);
            else
            begin
                len = $urandom_range(len_max, 1);
                cut = len;
                if (len > 1 && $urandom_range(99) < 10)
                    cut = $urandom_range(len - 1, 1);
                field = 22'(len);
                if (len == 1 && $urandom_range(1) == 1)
                    field = '0;
                offer_nal(field, cut);
                done += cut;
            end
            if (pause_midway && !paused && done >= items / 2)
            begin
                wait_drained();
                paused = 1'b1;
            end
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        offer_byte(8'($urandom), 22'($urandom), 1'b0);
        offer_nal(22'd0, 1);
        offer_nal(22'd3, 3);
        offer_nal(22'h3fffff, 3);
        wait_drained();

        set_config(7'd0, 32'd0, 32'hffffffff, 16'd0);
        offer_nal(22'd4, 4);
        offer_nal(22'd5, 5);
        offer_nal(22'd8, 3);
        wait_drained();
        set_config(7'd0, 32'd0, 32'hffffffff, 16'd20);
        repeat (5) offer_byte(8'($urandom), 22'($urandom), 1'b0);
        wait_drained();

        set_config(7'h7f, 32'hffffffff, 32'd0, 16'd16);
        run_phase(19, 67, 110, 40, 1'b1);
        wait_drained();
        set_config(7'($urandom), $urandom, $urandom, 16'($urandom_range(48, 17)));
        run_phase(67, 19, 110, 60, 1'b0);
        wait_drained();
        set_config(7'($urandom), $urandom, $urandom, 16'hffff);
        run_phase(0, 0, 100, 40, 1'b0);
        wait_drained();

        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: rtp_h264_packetizer.f
rtl/core/rtph264_pkg.sv
rtl/core/rtph264_front.sv
rtl/core/rtph264_jobq.sv
rtl/core/rtph264_back.sv
rtl/core/rtp_h264_packetizer.sv
rtl/core/rtph264_checker.sv
tb/sv/rtp_stream_checker.sv
tb/sv/testbench.sv
